@@ hdl/s5hrc_pkg.sv @@
// ----------------------------------------------------------------------------
// s5hrc_pkg: shared types and constants
// Types and constants used by the SOCKS5 reply checker modules.
// ----------------------------------------------------------------------------
package s5hrc_pkg;

    // Handshake phase
    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_AUTH   = 3'd1,
        PH_HEADER = 3'd2,
        PH_DOMLEN = 3'd3,
        PH_SKIP   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // Status codes reported with each item
    typedef enum logic [2:0] {
        ST_MORE          = 3'd0,
        ST_SEND_AUTH     = 3'd1,
        ST_SEND_CONNECT  = 3'd2,
        ST_READY         = 3'd3,
        ST_PROTO_ERR     = 3'd4,
        ST_AUTH_REQUIRED = 3'd5,
        ST_AUTH_REJECTED = 3'd6,
        ST_CONN_REJECTED = 3'd7
    } status_t;

    // Protocol byte values
    localparam logic [7:0] SOCKS_VERSION   = 8'h05;
    localparam logic [7:0] AUTH_VERSION    = 8'h01;
    localparam logic [7:0] METHOD_NONE     = 8'h00;
    localparam logic [7:0] METHOD_USERPASS = 8'h02;
    localparam logic [7:0] METHOD_REJECT   = 8'hFF;
    localparam logic [7:0] ATYP_IPV4       = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN     = 8'h03;
    localparam logic [7:0] ATYP_IPV6       = 8'h04;

    // Bound address plus port lengths
    localparam logic [8:0] SKIP_IPV4 = 9'd6;
    localparam logic [8:0] SKIP_IPV6 = 9'd18;
    localparam logic [8:0] PORT_LEN  = 9'd2;

    // Byte positions within a reply
    localparam logic [1:0] POS_FIRST  = 2'd0;
    localparam logic [1:0] POS_SECOND = 2'd1;
    localparam logic [1:0] POS_THIRD  = 2'd2;
    localparam logic [1:0] POS_FOURTH = 2'd3;

    // One input item
    typedef struct packed {
        logic       restart;
        logic [7:0] rx_byte;
    } item_t;

    // Input register to core
    typedef struct packed {
        logic  valid;
        item_t item;
    } in_stage_t;

endpackage

@@ hdl/s5hrc_in_stage.sv @@
// ----------------------------------------------------------------------------
// s5hrc_in_stage: input register
// Holds one accepted item until the core takes it; stalls the sender only
// when an item is held and the core cannot take it this cycle.
// ----------------------------------------------------------------------------
module s5hrc_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 restart,
    input  logic [7:0]           rx_byte,
    input  logic                 take,
    output s5hrc_pkg::in_stage_t stage
);

    logic             valid_reg;
    logic             valid_next;
    s5hrc_pkg::item_t item_reg;
    logic             load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    // Occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.restart <= restart;
            item_reg.rx_byte <= rx_byte;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

@@ hdl/s5hrc_core.sv @@
// ----------------------------------------------------------------------------
// s5hrc_core: handshake tracker and result register
// Checks one byte per cycle, while not stalled, against the current phase,
// updates the handshake state and loads the status into the result register.
// ----------------------------------------------------------------------------
module s5hrc_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 use_auth,
    input  s5hrc_pkg::in_stage_t stage,
    output logic                 take,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [7:0]           reply_code
);

    s5hrc_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]         pos_reg, pos_next;
    logic               bad_reg, bad_next;
    logic [7:0]         saved_code_reg, saved_code_next;
    logic [8:0]         skip_reg, skip_next;
    s5hrc_pkg::status_t final_reg, final_next;

    logic               out_valid_reg, out_valid_next;
    s5hrc_pkg::status_t status_reg;
    logic [7:0]         code_reg;

    s5hrc_pkg::status_t st;
    logic               fin;
    logic [7:0]         b;
    logic [7:0]         want_method;
    logic [8:0]         skip_dec;

    assign b           = stage.item.rx_byte;
    assign want_method = use_auth ? s5hrc_pkg::METHOD_USERPASS : s5hrc_pkg::METHOD_NONE;
    assign skip_dec    = (skip_reg != 9'd0) ? (skip_reg - 9'd1) : skip_reg;
    assign take        = stage.valid && (!out_valid_reg || !out_stall);

    // Status for this byte; fin marks a final outcome
    always_comb
    begin
        st  = s5hrc_pkg::ST_MORE;
        fin = 1'b0;
        unique case (phase_reg)
            s5hrc_pkg::PH_METHOD:
            begin
                if (pos_reg != s5hrc_pkg::POS_FIRST)
                begin
                    fin = 1'b1;
                    priority if (bad_reg)
                        st = s5hrc_pkg::ST_PROTO_ERR;
                    else if (b == s5hrc_pkg::METHOD_REJECT)
                        st = s5hrc_pkg::ST_AUTH_REQUIRED;
                    else if (b != want_method)
                        st = s5hrc_pkg::ST_PROTO_ERR;
                    else
                    begin
                        fin = 1'b0;
                        st  = use_auth ? s5hrc_pkg::ST_SEND_AUTH
                                       : s5hrc_pkg::ST_SEND_CONNECT;
                    end
                end
            end
            s5hrc_pkg::PH_AUTH:
            begin
                if (pos_reg != s5hrc_pkg::POS_FIRST)
                begin
                    if (bad_reg || b != 8'd0)
                    begin
                        fin = 1'b1;
                        st  = s5hrc_pkg::ST_AUTH_REJECTED;
                    end
                    else
                    begin
                        st = s5hrc_pkg::ST_SEND_CONNECT;
                    end
                end
            end
            s5hrc_pkg::PH_HEADER:
            begin
                if (pos_reg == s5hrc_pkg::POS_FOURTH)
                begin
                    priority if (bad_reg)
                    begin
                        fin = 1'b1;
                        st  = s5hrc_pkg::ST_PROTO_ERR;
                    end
                    else if (saved_code_reg != 8'd0)
                    begin
                        fin = 1'b1;
                        st  = s5hrc_pkg::ST_CONN_REJECTED;
                    end
                    else if (b != s5hrc_pkg::ATYP_IPV4 && b != s5hrc_pkg::ATYP_IPV6 &&
                             b != s5hrc_pkg::ATYP_DOMAIN)
                    begin
                        fin = 1'b1;
                        st  = s5hrc_pkg::ST_PROTO_ERR;
                    end
                    else
                    begin
                        st = s5hrc_pkg::ST_MORE;
                    end
                end
            end
            s5hrc_pkg::PH_DOMLEN:
            begin
                st = s5hrc_pkg::ST_MORE;
            end
            s5hrc_pkg::PH_SKIP:
            begin
                if (skip_dec == 9'd0)
                begin
                    fin = 1'b1;
                    st  = s5hrc_pkg::ST_READY;
                end
            end
            default:
            begin
                st = final_reg;
            end
        endcase
    end

    // Next handshake state
    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        bad_next        = bad_reg;
        saved_code_next = saved_code_reg;
        skip_next       = skip_reg;
        final_next      = final_reg;
        if (stage.item.restart)
        begin
            phase_next      = s5hrc_pkg::PH_METHOD;
            pos_next        = s5hrc_pkg::POS_FIRST;
            bad_next        = 1'b0;
            saved_code_next = 8'd0;
            skip_next       = 9'd0;
            final_next      = s5hrc_pkg::ST_MORE;
        end
        else if (fin)
        begin
            phase_next = s5hrc_pkg::PH_DONE;
            pos_next   = s5hrc_pkg::POS_FIRST;
            bad_next   = 1'b0;
            final_next = st;
            if (phase_reg == s5hrc_pkg::PH_SKIP)
            begin
                skip_next = skip_dec;
            end
        end
        else
        begin
            unique case (phase_reg)
                s5hrc_pkg::PH_METHOD, s5hrc_pkg::PH_AUTH:
                begin
                    if (pos_reg == s5hrc_pkg::POS_FIRST)
                    begin
                        bad_next = (phase_reg == s5hrc_pkg::PH_METHOD)
                                   ? (b != s5hrc_pkg::SOCKS_VERSION)
                                   : (b != s5hrc_pkg::AUTH_VERSION);
                        pos_next = s5hrc_pkg::POS_SECOND;
                    end
                    else
                    begin
                        phase_next = (st == s5hrc_pkg::ST_SEND_AUTH)
                                     ? s5hrc_pkg::PH_AUTH : s5hrc_pkg::PH_HEADER;
                        pos_next   = s5hrc_pkg::POS_FIRST;
                        bad_next   = 1'b0;
                    end
                end
                s5hrc_pkg::PH_HEADER:
                begin
                    unique case (pos_reg)
                        s5hrc_pkg::POS_FIRST:
                        begin
                            bad_next = (b != s5hrc_pkg::SOCKS_VERSION);
                            pos_next = s5hrc_pkg::POS_SECOND;
                        end
                        s5hrc_pkg::POS_SECOND:
                        begin
                            saved_code_next = b;
                            pos_next        = s5hrc_pkg::POS_THIRD;
                        end
                        s5hrc_pkg::POS_THIRD:
                        begin
                            bad_next = bad_reg || (b != 8'd0);
                            pos_next = s5hrc_pkg::POS_FOURTH;
                        end
                        default:
                        begin
                            // address type accepted
                            pos_next = s5hrc_pkg::POS_FIRST;
                            bad_next = 1'b0;
                            priority if (b == s5hrc_pkg::ATYP_IPV4)
                            begin
                                skip_next  = s5hrc_pkg::SKIP_IPV4;
                                phase_next = s5hrc_pkg::PH_SKIP;
                            end
                            else if (b == s5hrc_pkg::ATYP_IPV6)
                            begin
                                skip_next  = s5hrc_pkg::SKIP_IPV6;
                                phase_next = s5hrc_pkg::PH_SKIP;
                            end
                            else
                            begin
                                phase_next = s5hrc_pkg::PH_DOMLEN;
                            end
                        end
                    endcase
                end
                s5hrc_pkg::PH_DOMLEN:
                begin
                    skip_next  = {1'b0, b} + s5hrc_pkg::PORT_LEN;
                    phase_next = s5hrc_pkg::PH_SKIP;
                    pos_next   = s5hrc_pkg::POS_FIRST;
                    bad_next   = 1'b0;
                end
                s5hrc_pkg::PH_SKIP:
                begin
                    skip_next = skip_dec;
                end
                default:
                begin
                    // done: hold
                end
            endcase
        end
    end

    // Result register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= s5hrc_pkg::PH_METHOD;
            pos_reg        <= s5hrc_pkg::POS_FIRST;
            bad_reg        <= 1'b0;
            saved_code_reg <= 8'd0;
            skip_reg       <= 9'd0;
            final_reg      <= s5hrc_pkg::ST_MORE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                phase_reg      <= phase_next;
                pos_reg        <= pos_next;
                bad_reg        <= bad_next;
                saved_code_reg <= saved_code_next;
                skip_reg       <= skip_next;
                final_reg      <= final_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (stage.item.restart)
            begin
                status_reg <= s5hrc_pkg::ST_MORE;
                code_reg   <= 8'd0;
            end
            else
            begin
                status_reg <= st;
                code_reg   <= (st == s5hrc_pkg::ST_CONN_REJECTED) ? saved_code_reg : 8'd0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign reply_code = code_reg;

endmodule

@@ hdl/socks5_handshake_reply_checker_unit.sv @@
// ----------------------------------------------------------------------------
// socks5_handshake_reply_checker_unit: SOCKS5 client reply checker
// Follows the proxy side of a SOCKS5 client handshake, one byte per item.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while not stalled and returns one status
// item per byte: method reply, optional username/password reply, connect reply
// header, then the bound address and port are skipped. Throughput is one item
// per clock while out_stall is low; each byte passes the input register, then
// the whole per-byte check and state update, then the result register.
// Once a final status is reached it is repeated until an item with restart
// set. use_authentication is written through its own valid/ready port and is
// always ready; write it only while no items are in flight.
module socks5_handshake_reply_checker_unit (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       use_authentication,
    // input items
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       restart,
    input  logic [7:0] rx_byte,
    // result items
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] status,
    output logic [7:0] reply_code
);

    logic                 use_auth_reg;
    logic                 take;
    s5hrc_pkg::in_stage_t stage;

    assign cfg_ready = 1'b1;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_auth_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            use_auth_reg <= use_authentication;
        end
    end

    s5hrc_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .restart  (restart),
        .rx_byte  (rx_byte),
        .take     (take),
        .stage    (stage)
    );

    s5hrc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .use_auth   (use_auth_reg),
        .stage      (stage),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .reply_code (reply_code)
    );

endmodule
